FILE: sv/bmd_pkg.sv
// Package for the bipartite matching block: widths, limits, request codes.
// No dependencies; imported by the top level and the checker.
package bmd_pkg;

  localparam int VW            = 6;
  localparam int MAX_VERTICES  = 64;
  localparam int NODE_CAP      = MAX_VERTICES + 2;
  localparam int NW            = $clog2(NODE_CAP);
  localparam int LW            = $clog2(NODE_CAP + 1);
  localparam int VT_W          = 7;
  localparam int VT_RESET      = 64;
  localparam int EDGE_W        = 1 + 2 * VW;
  localparam int SIZE_W        = 6;
  localparam int RESULT_CAP    = 32;
  localparam int MAX_EDGES_DEF = 256;

  localparam logic [1:0] ACT_LEFT   = 2'd0;
  localparam logic [1:0] ACT_EDGE   = 2'd1;
  localparam logic [1:0] ACT_RUN    = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

endpackage

FILE: sv/bmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for edge, node and list stores.
module bmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/bipartite_matching_dinic_top.sv
// Top level of the bipartite maximum matching block (Dinic phases).
// Depends on bmd_pkg and bmd_ram.
//
// Load requests (declare left vertex, add edge) leave busy low, so they may
// arrive every cycle. A run request raises busy until the last result is out.
// A run is driven by one sequencer over an edge memory with one read and one
// write port. Scanning the adjacency of a graph vertex steps through every
// stored edge twice (forward and reverse half), each step an edge read and then
// a compare, with a further check step on a hit; the source and sink scan one
// vertex per cycle except on a hit. Each Dinic phase clears the node store,
// lays out layers and then walks augmenting paths. Emission reads the stored
// edges in turn and then gives the last result. Results come one per strobe on
// out_valid and the receiver cannot stall them; the last one carries out_last.
module bipartite_matching_dinic_top
  import bmd_pkg::*;
#(
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_action,
  input  logic [VW-1:0]     in_vertex_u,
  input  logic [VW-1:0]     in_vertex_v,
  input  logic              cfg_wr_en,
  input  logic [VT_W-1:0]   cfg_wr_data,
  output logic              out_valid,
  output logic [VW-1:0]     out_left_vertex,
  output logic [VW-1:0]     out_right_vertex,
  output logic              out_pair_valid,
  output logic              out_last,
  output logic [SIZE_W-1:0] out_match_size,
  output logic              out_edge_overflow
);

  localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW    = $clog2(MAX_EDGES + 1);
  localparam int PWE   = $clog2(2 * MAX_EDGES + 2);
  localparam int PW    = (PWE > NW) ? PWE : NW;
  localparam int NWORD = LW + PW;
  localparam logic [PW-1:0] VPOS = PW'(2 * MAX_EDGES);
  localparam logic [LW-1:0] UNR  = '1;

  typedef enum logic [4:0] {
    S_IDLE, S_R0, S_PH, S_CLR, S_BI, S_BQ, S_BV, S_BL, S_BD, S_BS,
    S_DI, S_DT, S_DV, S_DL, S_FR, S_FE, S_WE, S_P0, S_P1, S_P2,
    S_AF, S_F0, S_F1, S_F2, S_F3, S_FN, S_E0, S_E1, S_E2, S_E3
  } state_t;

  state_t                  state_r, state_nxt;
  logic [VT_W-1:0]         vt_r, vt_nxt;
  logic [MAX_VERTICES-1:0] left_r, left_nxt;
  logic [MAX_VERTICES-1:0] vsat_r, vsat_nxt;
  logic [CW-1:0]           et_r, et_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [NW-1:0]           n_r, n_nxt;
  logic [NW-1:0]           flow_r, flow_nxt;
  logic [NW-1:0]           before_r, before_nxt;
  logic [NW-1:0]           ph_r, ph_nxt;
  logic [NW-1:0]           a_r, a_nxt;
  logic [NW-1:0]           head_r, head_nxt;
  logic [NW-1:0]           tail_r, tail_nxt;
  logic [NW-1:0]           depth_r, depth_nxt;
  logic [NW-1:0]           v_r, v_nxt;
  logic [NW-1:0]           fw_r, fw_nxt;
  logic [LW-1:0]           lv_r, lv_nxt;
  logic [PW-1:0]           pos_r, pos_nxt;
  logic                    dfs_r, dfs_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [SIZE_W-1:0]       cnt_r, cnt_nxt;
  logic                    pend_r, pend_nxt;
  logic [VW-1:0]           pl_r, pl_nxt;
  logic [VW-1:0]           pr_r, pr_nxt;
  logic                    ov_r, ov_nxt;
  logic [VW-1:0]           ol_r, ol_nxt;
  logic [VW-1:0]           or_r, or_nxt;
  logic                    opv_r, opv_nxt;
  logic                    olast_r, olast_nxt;
  logic [SIZE_W-1:0]       osize_r, osize_nxt;
  logic                    oovf_r, oovf_nxt;

  logic              e_we;
  logic [EAW-1:0]    e_wa, e_ra;
  logic [EDGE_W-1:0] e_wd, e_rd;
  logic              nd_we;
  logic [NW-1:0]     nd_wa, nd_ra;
  logic [NWORD-1:0]  nd_wd, nd_rd;
  logic              ls_we;
  logic [NW-1:0]     ls_wa, ls_ra, ls_wd, ls_rd;

  bmd_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd)
  );
  bmd_ram #(.WIDTH(NWORD), .DEPTH(NODE_CAP)) u_node_ram (
    .clk(clk), .we(nd_we), .waddr(nd_wa), .wdata(nd_wd), .raddr(nd_ra), .rdata(nd_rd)
  );
  bmd_ram #(.WIDTH(NW), .DEPTH(NODE_CAP)) u_list_ram (
    .clk(clk), .we(ls_we), .waddr(ls_wa), .wdata(ls_wd), .raddr(ls_ra), .rdata(ls_rd)
  );

  // edge word: {used, left end, right end}
  logic [VW-1:0] e_u, e_v;
  logic          e_used, e_ok;
  logic [LW-1:0] nd_layer;
  logic [PW-1:0] nd_cur;
  logic [PW-2:0] pidx, c_idx;
  logic [NW-1:0] src, snk, nodes;
  logic          is_src, is_snk;
  logic [VW-1:0] vi, vvi;

  assign e_u      = e_rd[2*VW-1:VW];
  assign e_v      = e_rd[VW-1:0];
  assign e_used   = e_rd[EDGE_W-1];
  assign e_ok     = (NW'(e_u) < n_r) && (NW'(e_v) < n_r) && left_r[e_u];
  assign nd_layer = nd_rd[NWORD-1:PW];
  assign nd_cur   = nd_rd[PW-1:0];
  assign pidx     = pos_r[PW-1:1];
  assign c_idx    = nd_cur[PW-1:1];
  assign src      = n_r;
  assign snk      = NW'(n_r + 1'b1);
  assign nodes    = NW'(n_r + 2'd2);
  assign is_src   = (v_r == src);
  assign is_snk   = (v_r == snk);
  assign vi       = pos_r[VW-1:0];
  assign vvi      = v_r[VW-1:0];

  // adjacency step of the current node at pos_r
  logic          f_hit, f_end, f_rd, f_jmp;
  logic [NW-1:0] f_w;

  always_comb begin
    f_hit = 1'b0;
    f_end = 1'b0;
    f_rd  = 1'b0;
    f_jmp = 1'b0;
    f_w   = '0;
    if (state_r == S_FE) begin
      f_w   = pos_r[0] ? NW'(e_u) : NW'(e_v);
      f_hit = e_ok && (pos_r[0] ? (e_v == vvi) : (e_u == vvi))
              && (pos_r[0] ? e_used : !e_used);
    end else if (is_src || is_snk) begin
      if (pos_r >= PW'(n_r)) begin
        f_end = 1'b1;
      end else begin
        f_w   = NW'(vi);
        f_hit = is_src ? (left_r[vi] && !vsat_r[vi]) : (!left_r[vi] && vsat_r[vi]);
      end
    end else if ({1'b0, pidx} < PW'(et_r)) begin
      f_rd = 1'b1;
    end else if (pos_r < VPOS) begin
      f_jmp = 1'b1;
    end else if (pos_r == VPOS) begin
      f_w   = left_r[vvi] ? src : snk;
      f_hit = left_r[vvi] ? vsat_r[vvi] : !vsat_r[vvi];
    end else begin
      f_end = 1'b1;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    vt_nxt     = vt_r;
    left_nxt   = left_r;
    vsat_nxt   = vsat_r;
    et_nxt     = et_r;
    ovf_nxt    = ovf_r;
    n_nxt      = n_r;
    flow_nxt   = flow_r;
    before_nxt = before_r;
    ph_nxt     = ph_r;
    a_nxt      = a_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    depth_nxt  = depth_r;
    v_nxt      = v_r;
    fw_nxt     = fw_r;
    lv_nxt     = lv_r;
    pos_nxt    = pos_r;
    dfs_nxt    = dfs_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    pl_nxt     = pl_r;
    pr_nxt     = pr_r;
    ov_nxt     = 1'b0;
    ol_nxt     = ol_r;
    or_nxt     = or_r;
    opv_nxt    = opv_r;
    olast_nxt  = olast_r;
    osize_nxt  = osize_r;
    oovf_nxt   = oovf_r;
    e_we  = 1'b0;
    e_wa  = '0;
    e_wd  = '0;
    e_ra  = '0;
    nd_we = 1'b0;
    nd_wa = '0;
    nd_wd = '0;
    nd_ra = '0;
    ls_we = 1'b0;
    ls_wa = '0;
    ls_wd = '0;
    ls_ra = '0;

    if (cfg_wr_en) begin
      vt_nxt = cfg_wr_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_action)
            ACT_LEFT: left_nxt[in_vertex_u] = 1'b1;
            ACT_EDGE: begin
              if (et_r < CW'(MAX_EDGES)) begin
                e_we   = 1'b1;
                e_wa   = et_r[EAW-1:0];
                e_wd   = {1'b0, in_vertex_u, in_vertex_v};
                et_nxt = CW'(et_r + 1'b1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            ACT_RUN: state_nxt = S_R0;
            default: ;
          endcase
        end
      end
      S_R0: begin
        if (vt_r == '0) begin
          n_nxt = NW'(1);
        end else if (vt_r > VT_W'(MAX_VERTICES)) begin
          n_nxt = NW'(MAX_VERTICES);
        end else begin
          n_nxt = NW'(vt_r);
        end
        flow_nxt  = '0;
        ph_nxt    = '0;
        vsat_nxt  = '0;
        state_nxt = S_PH;
      end
      S_PH: begin
        if (ph_r == nodes) begin
          state_nxt = S_E0;
        end else begin
          before_nxt = flow_r;
          a_nxt      = '0;
          state_nxt  = S_CLR;
        end
      end
      S_CLR: begin
        nd_we = 1'b1;
        nd_wa = a_r;
        nd_wd = {UNR, PW'(0)};
        a_nxt = NW'(a_r + 1'b1);
        if (a_r == NW'(nodes - 1'b1)) begin
          state_nxt = S_BI;
        end
      end
      S_BI: begin
        nd_we     = 1'b1;
        nd_wa     = src;
        nd_wd     = '0;
        ls_we     = 1'b1;
        ls_wa     = '0;
        ls_wd     = src;
        head_nxt  = '0;
        tail_nxt  = NW'(1);
        state_nxt = S_BQ;
      end
      S_BQ: begin
        ls_ra = head_r;
        state_nxt = (head_r == tail_r) ? S_BD : S_BV;
      end
      S_BV: begin
        v_nxt     = ls_rd;
        nd_ra     = ls_rd;
        state_nxt = S_BL;
      end
      S_BL: begin
        lv_nxt    = nd_layer;
        pos_nxt   = '0;
        dfs_nxt   = 1'b0;
        state_nxt = S_FR;
      end
      S_BD: begin
        nd_ra     = snk;
        state_nxt = S_BS;
      end
      S_BS: begin
        state_nxt = (nd_layer == UNR) ? S_E0 : S_DI;
      end
      S_DI: begin
        ls_we     = 1'b1;
        ls_wa     = '0;
        ls_wd     = src;
        depth_nxt = NW'(1);
        state_nxt = S_DT;
      end
      S_DT: begin
        ls_ra     = NW'(depth_r - 1'b1);
        state_nxt = S_DV;
      end
      S_DV: begin
        v_nxt = ls_rd;
        if (ls_rd == snk) begin
          head_nxt  = '0;
          state_nxt = S_F0;
        end else begin
          nd_ra     = ls_rd;
          state_nxt = S_DL;
        end
      end
      S_DL: begin
        lv_nxt    = nd_layer;
        pos_nxt   = nd_cur;
        dfs_nxt   = 1'b1;
        state_nxt = S_FR;
      end
      S_FR, S_FE: begin
        if (f_rd) begin
          e_ra      = pidx[EAW-1:0];
          state_nxt = S_FE;
        end else if (f_jmp) begin
          pos_nxt = VPOS;
        end else if (f_end) begin
          if (dfs_r) begin
            nd_we     = 1'b1;
            nd_wa     = v_r;
            nd_wd     = {lv_r, pos_r};
            state_nxt = S_P0;
          end else begin
            head_nxt  = NW'(head_r + 1'b1);
            state_nxt = S_BQ;
          end
        end else if (f_hit) begin
          fw_nxt    = f_w;
          nd_ra     = f_w;
          state_nxt = S_WE;
        end else begin
          pos_nxt   = PW'(pos_r + 1'b1);
          state_nxt = S_FR;
        end
      end
      S_WE: begin
        pos_nxt   = PW'(pos_r + 1'b1);
        state_nxt = S_FR;
        if (!dfs_r) begin
          if (nd_layer == UNR && tail_r < nodes) begin
            nd_we    = 1'b1;
            nd_wa    = fw_r;
            nd_wd    = {LW'(lv_r + 1'b1), PW'(0)};
            ls_we    = 1'b1;
            ls_wa    = tail_r;
            ls_wd    = fw_r;
            tail_nxt = NW'(tail_r + 1'b1);
          end
        end else if (nd_layer == LW'(lv_r + 1'b1) && depth_r < NW'(NODE_CAP)) begin
          nd_we     = 1'b1;
          nd_wa     = v_r;
          nd_wd     = {lv_r, pos_r};
          ls_we     = 1'b1;
          ls_wa     = depth_r;
          ls_wd     = fw_r;
          depth_nxt = NW'(depth_r + 1'b1);
          pos_nxt   = pos_r;
          state_nxt = S_DT;
        end
      end
      S_P0: begin
        if (depth_r == NW'(1)) begin
          state_nxt = S_AF;
        end else begin
          depth_nxt = NW'(depth_r - 1'b1);
          ls_ra     = NW'(depth_r - 2'd2);
          state_nxt = S_P1;
        end
      end
      S_P1: begin
        v_nxt     = ls_rd;
        nd_ra     = ls_rd;
        state_nxt = S_P2;
      end
      S_P2: begin
        nd_we     = 1'b1;
        nd_wa     = v_r;
        nd_wd     = {nd_layer, PW'(nd_cur + 1'b1)};
        state_nxt = S_DT;
      end
      S_AF: begin
        if (flow_r == before_r) begin
          state_nxt = S_E0;
        end else begin
          ph_nxt    = NW'(ph_r + 1'b1);
          state_nxt = S_PH;
        end
      end
      S_F0: begin
        ls_ra     = head_r;
        state_nxt = S_F1;
      end
      S_F1: begin
        v_nxt     = ls_rd;
        nd_ra     = ls_rd;
        state_nxt = S_F2;
      end
      S_F2: begin
        pos_nxt   = nd_cur;
        state_nxt = S_FN;
        if (is_src) begin
          vsat_nxt[nd_cur[VW-1:0]] = ~vsat_r[nd_cur[VW-1:0]];
        end else if (nd_cur == VPOS) begin
          vsat_nxt[vvi] = ~vsat_r[vvi];
        end else begin
          e_ra      = c_idx[EAW-1:0];
          state_nxt = S_F3;
        end
      end
      S_F3: begin
        e_we      = 1'b1;
        e_wa      = pidx[EAW-1:0];
        e_wd      = {~e_used, e_rd[EDGE_W-2:0]};
        state_nxt = S_FN;
      end
      S_FN: begin
        head_nxt = NW'(head_r + 1'b1);
        if (NW'(head_r + 1'b1) == NW'(depth_r - 1'b1)) begin
          flow_nxt  = NW'(flow_r + 1'b1);
          state_nxt = S_DI;
        end else begin
          state_nxt = S_F0;
        end
      end
      S_E0: begin
        idx_nxt   = '0;
        cnt_nxt   = '0;
        pend_nxt  = 1'b0;
        state_nxt = S_E1;
      end
      S_E1: begin
        e_ra = idx_r[EAW-1:0];
        if (idx_r < et_r && cnt_r < SIZE_W'(RESULT_CAP)) begin
          state_nxt = S_E2;
        end else begin
          state_nxt = S_E3;
        end
      end
      S_E2: begin
        idx_nxt   = CW'(idx_r + 1'b1);
        state_nxt = S_E1;
        if (e_ok && e_used) begin
          if (pend_r) begin
            ov_nxt    = 1'b1;
            ol_nxt    = pl_r;
            or_nxt    = pr_r;
            opv_nxt   = 1'b1;
            olast_nxt = 1'b0;
            osize_nxt = flow_r[SIZE_W-1:0];
            oovf_nxt  = ovf_r;
          end
          pend_nxt = 1'b1;
          pl_nxt   = e_u;
          pr_nxt   = e_v;
          cnt_nxt  = SIZE_W'(cnt_r + 1'b1);
        end
      end
      S_E3: begin
        ov_nxt    = 1'b1;
        ol_nxt    = pend_r ? pl_r : '0;
        or_nxt    = pend_r ? pr_r : '0;
        opv_nxt   = pend_r;
        olast_nxt = 1'b1;
        osize_nxt = pend_r ? flow_r[SIZE_W-1:0] : '0;
        oovf_nxt  = ovf_r;
        left_nxt  = '0;
        vsat_nxt  = '0;
        et_nxt    = '0;
        ovf_nxt   = 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vt_r    <= VT_W'(VT_RESET);
      left_r  <= '0;
      vsat_r  <= '0;
      et_r    <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vt_r    <= vt_nxt;
      left_r  <= left_nxt;
      vsat_r  <= vsat_nxt;
      et_r    <= et_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
    end
    n_r      <= n_nxt;
    flow_r   <= flow_nxt;
    before_r <= before_nxt;
    ph_r     <= ph_nxt;
    a_r      <= a_nxt;
    head_r   <= head_nxt;
    tail_r   <= tail_nxt;
    depth_r  <= depth_nxt;
    v_r      <= v_nxt;
    fw_r     <= fw_nxt;
    lv_r     <= lv_nxt;
    pos_r    <= pos_nxt;
    dfs_r    <= dfs_nxt;
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
    pend_r   <= pend_nxt;
    pl_r     <= pl_nxt;
    pr_r     <= pr_nxt;
    ol_r     <= ol_nxt;
    or_r     <= or_nxt;
    opv_r    <= opv_nxt;
    olast_r  <= olast_nxt;
    osize_r  <= osize_nxt;
    oovf_r   <= oovf_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = ov_r;
  assign out_left_vertex   = ol_r;
  assign out_right_vertex  = or_r;
  assign out_pair_valid    = opv_r;
  assign out_last          = olast_r;
  assign out_match_size    = osize_r;
  assign out_edge_overflow = oovf_r;

endmodule

FILE: sv/bmd_chk.sv
// Port-level checker for the bipartite matching block, bound to the top level.
// Depends on bmd_pkg.
module bmd_chk
  import bmd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [1:0]        in_action,
  input logic              out_valid,
  input logic              out_pair_valid,
  input logic              out_last,
  input logic [SIZE_W-1:0] out_match_size
);

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pair_valid |-> out_last)
    else $error("empty result without last");

  a_empty_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pair_valid |-> out_match_size == '0)
    else $error("empty result with nonzero size");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_action == ACT_RUN |=> busy)
    else $error("run request did not raise busy");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> busy)
    else $error("run ended after a non-last result");

endmodule

bind bipartite_matching_dinic_top bmd_chk u_bmd_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_action(in_action),
  .out_valid(out_valid), .out_pair_valid(out_pair_valid), .out_last(out_last),
  .out_match_size(out_match_size)
);
